### sv/dmwc_pkg.sv
// Shared types and constants for the direct-mapped write-back cache.
// Holds the sequencer state type, command codes and fixed field widths.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dmwc_pkg;

   // Fixed widths of the request and response fields.
   localparam int ADDR_FIELD_W = 16;
   localparam int BYTE_W       = 8;
   // Stored tags never keep more than this many bits.
   localparam int MAX_TAG_W    = 8;

   typedef logic [BYTE_W-1:0]       byte_type;
   typedef logic [ADDR_FIELD_W-1:0] addr_field_type;

   // Request command codes.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_MOVE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

### sv/dmwc_line_store.sv
// Cache line storage: tag/dirty memory per set and byte data memory.
// Both are simple dual-port memories with a registered read port.
// Depends on dmwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmwc_line_store #(
   parameter int SET_BITS = 5,
   parameter int OFF_BITS = 3,
   parameter int TAG_W    = 8
) (
   input  wire logic                          clock,
   input  wire logic                          meta_we,
   input  wire logic [SET_BITS-1:0]           meta_waddr,
   input  wire logic [TAG_W:0]                meta_wdata,
   input  wire logic [SET_BITS-1:0]           meta_raddr,
   output logic      [TAG_W:0]                meta_rdata,
   input  wire logic                          data_we,
   input  wire logic [SET_BITS+OFF_BITS-1:0]  data_waddr,
   input  wire dmwc_pkg::byte_type            data_wdata,
   input  wire logic [SET_BITS+OFF_BITS-1:0]  data_raddr,
   output dmwc_pkg::byte_type                 data_rdata
);
   import dmwc_pkg::*;

   localparam int NUM_LINES = 2 ** SET_BITS;
   localparam int NUM_BYTES = 2 ** (SET_BITS + OFF_BITS);

   // Each metadata word is the dirty mark above the tag.
   logic [TAG_W:0] meta_mem [NUM_LINES];
   byte_type       data_mem [NUM_BYTES];

   logic [TAG_W:0] meta_rdata_ff;
   byte_type       data_rdata_ff;

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rdata_ff <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_waddr] <= data_wdata;
      end
      data_rdata_ff <= data_mem[data_raddr];
   end

   assign meta_rdata = meta_rdata_ff;
   assign data_rdata = data_rdata_ff;

endmodule

`default_nettype wire

### sv/dmwc_backing_store.sv
// Byte-wide backing memory behind the cache.
// Simple dual-port memory with a registered read port.
// Depends on dmwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmwc_backing_store #(
   parameter int ADDR_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire dmwc_pkg::byte_type   wdata,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output dmwc_pkg::byte_type        rdata
);
   import dmwc_pkg::*;

   localparam int DEPTH = 2 ** ADDR_BITS;

   byte_type mem [DEPTH];
   byte_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/direct_mapped_writeback_cache.sv
// Direct-mapped write-back byte cache. A read hit passes through lookup and then a
// response state that loads the response register; a write hit writes its byte during
// lookup. A miss adds a combined write-back and refill sweep over the line. One
// request is in flight at a time; the line move is bounded by the single byte port
// on each memory. After reset a clearing pass zeroes all memories, during which no
// request is accepted.
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_writeback_cache #(
   // Number of lines and line size must be powers of two.
   parameter int NUM_SETS   = 32,
   parameter int LINE_BYTES = 8,
   parameter int ADDR_BITS  = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_command,
   input  wire dmwc_pkg::addr_field_type req_address,
   input  wire dmwc_pkg::byte_type       req_write_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output dmwc_pkg::byte_type            rsp_read_data,
   output logic                          rsp_hit,
   output logic                          rsp_line_dirty
);
   import dmwc_pkg::*;

   // Address decomposition. The tag is whatever lies above set and offset,
   // capped at the stored tag width; higher tag bits are dropped entirely.
   localparam int SET_BITS  = $clog2(NUM_SETS);
   localparam int OFF_BITS  = $clog2(LINE_BYTES);
   localparam int CIDX_BITS = SET_BITS + OFF_BITS;
   localparam int TAG_RAW   = ADDR_BITS - CIDX_BITS;
   localparam int TAG_W     = (TAG_RAW > MAX_TAG_W) ? MAX_TAG_W :
                              ((TAG_RAW < 1) ? 1 : TAG_RAW);
   // The sweep counter runs from zero up to LINE_BYTES inclusive.
   localparam int CNT_W     = OFF_BITS + 1;

   typedef logic [ADDR_BITS-1:0] maddr_type;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type            state_ff, state_in;
   maddr_type            clr_ff, clr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // Latched request.
   logic                 cmd_ff, cmd_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [SET_BITS-1:0]  set_ff, set_in;
   logic [OFF_BITS-1:0]  off_ff, off_in;
   byte_type             wdata_ff, wdata_in;

   // Lookup results kept for the sweep and the response.
   logic [TAG_W-1:0]     old_tag_ff, old_tag_in;
   logic                 hit_ff, hit_in;
   logic                 dirty_ff, dirty_in;
   byte_type             byte_ff, byte_in;

   // Response register, which lets the response wait without holding the
   // request side.
   logic                 rsp_valid_ff, rsp_valid_in;
   byte_type             rsp_data_ff, rsp_data_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_dirty_ff, rsp_dirty_in;

   // ------------------------------------------------------------------
   // Memory ports
   // ------------------------------------------------------------------
   logic                 meta_we;
   logic [SET_BITS-1:0]  meta_waddr, meta_raddr;
   logic [TAG_W:0]       meta_wdata, meta_rdata;
   logic                 data_we;
   logic [CIDX_BITS-1:0] data_waddr, data_raddr;
   byte_type             data_wdata, data_rdata;
   logic                 bk_we;
   maddr_type            bk_waddr, bk_raddr;
   byte_type             bk_wdata, bk_rdata;

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   maddr_type            req_addr;
   maddr_type            req_tag_sh;
   logic                 req_accept;
   logic                 rsp_load;

   // Line bases of the victim and of the requested line.
   maddr_type            old_base, new_base;
   logic [OFF_BITS-1:0]  prev_off;
   logic                 sweep_last;
   logic                 lookup_hit;

   assign req_addr   = ADDR_BITS'(req_address);
   assign req_tag_sh = req_addr >> CIDX_BITS;
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   assign old_base = (maddr_type'(old_tag_ff) << CIDX_BITS) |
                     (maddr_type'(set_ff) << OFF_BITS);
   assign new_base = (maddr_type'(tag_ff) << CIDX_BITS) |
                     (maddr_type'(set_ff) << OFF_BITS);

   // During the sweep, step c reads byte c of the line from both memories and
   // writes byte c-1 with the data read in step c-1.
   assign prev_off   = OFF_BITS'(cnt_ff - CNT_W'(1));
   assign sweep_last = (cnt_ff == CNT_W'(LINE_BYTES));
   assign lookup_hit = (meta_rdata[TAG_W-1:0] == tag_ff);

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cnt_in     = cnt_ff;
      cmd_in     = cmd_ff;
      tag_in     = tag_ff;
      set_in     = set_ff;
      off_in     = off_ff;
      wdata_in   = wdata_ff;
      old_tag_in = old_tag_ff;
      hit_in     = hit_ff;
      dirty_in   = dirty_ff;
      byte_in    = byte_ff;
      rsp_load   = 1'b0;

      meta_we    = 1'b0;
      meta_waddr = set_ff;
      meta_wdata = {1'b0, tag_ff};
      meta_raddr = set_ff;
      data_we    = 1'b0;
      data_waddr = {set_ff, off_ff};
      data_wdata = wdata_ff;
      data_raddr = {set_ff, cnt_ff[OFF_BITS-1:0]};
      bk_we      = 1'b0;
      bk_waddr   = old_base + maddr_type'(prev_off);
      bk_wdata   = data_rdata;
      bk_raddr   = new_base + maddr_type'(cnt_ff[OFF_BITS-1:0]);

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero every memory entry, one address per cycle.
            bk_we      = 1'b1;
            bk_waddr   = clr_ff;
            bk_wdata   = '0;
            data_we    = 1'b1;
            data_waddr = clr_ff[CIDX_BITS-1:0];
            data_wdata = '0;
            meta_we    = 1'b1;
            meta_waddr = clr_ff[SET_BITS-1:0];
            meta_wdata = '0;
            clr_in     = clr_ff + maddr_type'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            // Look up the incoming request's set and byte straight away.
            meta_raddr = req_addr[CIDX_BITS-1:OFF_BITS];
            data_raddr = req_addr[CIDX_BITS-1:0];
            if (req_accept) begin
               cmd_in   = req_command;
               tag_in   = req_tag_sh[TAG_W-1:0];
               set_in   = req_addr[CIDX_BITS-1:OFF_BITS];
               off_in   = req_addr[OFF_BITS-1:0];
               wdata_in = req_write_data;
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            hit_in     = lookup_hit;
            dirty_in   = meta_rdata[TAG_W];
            old_tag_in = meta_rdata[TAG_W-1:0];
            byte_in    = data_rdata;
            cnt_in     = '0;
            if (lookup_hit) begin
               if (cmd_ff == CMD_WRITE) begin
                  data_we    = 1'b1;
                  meta_we    = 1'b1;
                  meta_wdata = {1'b1, tag_ff};
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_MOVE;
            end
         end

         ST_MOVE: begin
            if (cnt_ff != '0) begin
               // Refill byte c-1; a write miss merges its byte over the refill.
               data_we    = 1'b1;
               data_waddr = {set_ff, prev_off};
               if ((prev_off == off_ff) && (cmd_ff == CMD_WRITE)) begin
                  data_wdata = wdata_ff;
               end else begin
                  data_wdata = bk_rdata;
               end
               if (prev_off == off_ff) begin
                  byte_in = bk_rdata;
               end
               // A dirty victim goes back to its own line address.
               bk_we = dirty_ff;
            end
            if (sweep_last) begin
               meta_we    = 1'b1;
               meta_wdata = {(cmd_ff == CMD_WRITE), tag_ff};
               if (cmd_ff == CMD_WRITE) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Response register next values.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_dirty_in = rsp_dirty_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = byte_ff;
         rsp_hit_in   = hit_ff;
         rsp_dirty_in = dirty_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      tag_ff       <= tag_in;
      set_ff       <= set_in;
      off_ff       <= off_in;
      wdata_ff     <= wdata_in;
      old_tag_ff   <= old_tag_in;
      hit_ff       <= hit_in;
      dirty_ff     <= dirty_in;
      byte_ff      <= byte_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_dirty_ff <= rsp_dirty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_line_dirty = rsp_dirty_ff;

   // ------------------------------------------------------------------
   // Memories
   // ------------------------------------------------------------------
   dmwc_line_store #(
      .SET_BITS (SET_BITS),
      .OFF_BITS (OFF_BITS),
      .TAG_W    (TAG_W)
   ) u_line_store (
      .clock      (clock),
      .meta_we    (meta_we),
      .meta_waddr (meta_waddr),
      .meta_wdata (meta_wdata),
      .meta_raddr (meta_raddr),
      .meta_rdata (meta_rdata),
      .data_we    (data_we),
      .data_waddr (data_waddr),
      .data_wdata (data_wdata),
      .data_raddr (data_raddr),
      .data_rdata (data_rdata)
   );

   dmwc_backing_store #(
      .ADDR_BITS (ADDR_BITS)
   ) u_backing_store (
      .clock (clock),
      .we    (bk_we),
      .waddr (bk_waddr),
      .wdata (bk_wdata),
      .raddr (bk_raddr),
      .rdata (bk_rdata)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted request did not move to lookup");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE) |-> (cnt_ff <= CNT_W'(LINE_BYTES)))
      else $error("line sweep counter overran the line");

   a_finish_is_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (cmd_ff == CMD_READ))
      else $error("write request reached the response state");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside the response state");

   a_backing_write_src: assert property (@(posedge clock) disable iff (reset)
      bk_we |-> ((state_ff == ST_CLEAR) || ((state_ff == ST_MOVE) && dirty_ff)))
      else $error("backing memory written without a dirty victim");

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the direct-mapped write-back byte cache.
// Depends on dmwc_pkg and direct_mapped_writeback_cache; a scoreboard class mirrors
// the cache and its backing memory to predict every read response.
`timescale 1ns / 1ps

// Mirror of the cache state. Every accepted request updates it in order, and
// every read leaves one expected response behind.
class cache_scoreboard;
   localparam int SETS       = 32;
   localparam int LINE_SIZE  = 8;
   localparam int MEM_BYTES  = 65536;

   typedef struct {
      dmwc_pkg::byte_type read_data;
      logic               hit;
      logic               line_dirty;
   } read_result_type;

   logic [7:0]         tag_of_set   [SETS];
   logic               dirty_of_set [SETS];
   dmwc_pkg::byte_type cached_bytes [SETS*LINE_SIZE];
   dmwc_pkg::byte_type memory_bytes [MEM_BYTES];
   read_result_type    expected_reads[$];
   int                 failures;

   // After reset every line holds tag 0 and zero bytes, as does memory.
   function void clear();
      foreach (tag_of_set[i]) tag_of_set[i] = '0;
      foreach (dirty_of_set[i]) dirty_of_set[i] = 1'b0;
      foreach (cached_bytes[i]) cached_bytes[i] = '0;
      foreach (memory_bytes[i]) memory_bytes[i] = '0;
      expected_reads.delete();
      failures = 0;
   endfunction

   function int outstanding();
      return expected_reads.size();
   endfunction

   // Apply one accepted request to the mirror.
   function void note_request(logic command, dmwc_pkg::addr_field_type address,
                              dmwc_pkg::byte_type write_data);
      logic [7:0]      tag;
      logic [4:0]      set;
      logic [2:0]      offset;
      logic            hit;
      logic            was_dirty;
      read_result_type result;
      tag       = address[15:8];
      set       = address[7:3];
      offset    = address[2:0];
      hit       = (tag_of_set[set] == tag);
      was_dirty = dirty_of_set[set];
      if (!hit) begin
         // A dirty victim goes back to its own line address; a clean one is dropped.
         if (was_dirty) begin
            for (int i = 0; i < LINE_SIZE; i++)
               memory_bytes[{tag_of_set[set], set, 3'(i)}] = cached_bytes[{set, 3'(i)}];
         end
         for (int i = 0; i < LINE_SIZE; i++)
            cached_bytes[{set, 3'(i)}] = memory_bytes[{tag, set, 3'(i)}];
         tag_of_set[set]   = tag;
         dirty_of_set[set] = 1'b0;
      end
      if (command == dmwc_pkg::CMD_WRITE) begin
         cached_bytes[{set, offset}] = write_data;
         dirty_of_set[set]           = 1'b1;
      end else begin
         result.read_data  = cached_bytes[{set, offset}];
         result.hit        = hit;
         result.line_dirty = was_dirty;
         expected_reads.insert(expected_reads.size(), result);
      end
   endfunction

   // Compare one accepted response with the oldest expected read.
   function void check_response(dmwc_pkg::byte_type read_data, logic hit, logic line_dirty);
      read_result_type want;
      if (expected_reads.size() == 0) begin
         $error("response with no read outstanding: read_data %0h hit %0b line_dirty %0b",
                read_data, hit, line_dirty);
         failures++;
         return;
      end
      want = expected_reads.pop_front();
      if (read_data !== want.read_data) begin
         $error("read_data mismatch: expected %0h, actual %0h", want.read_data, read_data);
         failures++;
      end
      if (hit !== want.hit) begin
         $error("hit mismatch: expected %0b, actual %0b", want.hit, hit);
         failures++;
      end
      if (line_dirty !== want.line_dirty) begin
         $error("line_dirty mismatch: expected %0b, actual %0b", want.line_dirty, line_dirty);
         failures++;
      end
   endfunction
endclass

module testbench;
   import dmwc_pkg::*;

   // The run is mostly the clearing pass plus about 825 words, so this limit
   // leaves a wide margin.
   localparam int CYCLE_LIMIT   = 1_000_000;
   // A write miss can still be sweeping a line when the last read returns.
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASE_ITEMS   = 200;

   logic           clock = 1'b0;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   logic           req_command;
   addr_field_type req_address;
   byte_type       req_write_data;
   logic           rsp_valid;
   logic           rsp_stall;
   byte_type       rsp_read_data;
   logic           rsp_hit;
   logic           rsp_line_dirty;

   cache_scoreboard board = new;

   // Percent of cycles in which the sender holds back and the receiver stalls.
   int             send_idle_pct = 0;
   int             stall_pct     = 0;
   int             cycle_count   = 0;
   // Tags that most random words use, so lines get hit, dirtied and evicted often.
   logic [7:0]     hot_tags [4];

   direct_mapped_writeback_cache u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_hit        (rsp_hit),
      .rsp_line_dirty (rsp_line_dirty)
   );

   always #5 clock = ~clock;

   // The receiver decides at each falling edge whether to stall the next edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Responses are taken at the rising edge, where both sides see the same
   // pre-edge values of valid and stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.check_response(rsp_read_data, rsp_hit, rsp_line_dirty);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Present one word and hold it until the cache takes it. The task is entered
   // and left at a falling edge, so valid stays high between back-to-back words
   // and changes at most once per time step.
   task automatic send_request(logic command, addr_field_type address, byte_type write_data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= command;
      req_address    <= address;
      req_write_data <= write_data;
      do @(posedge clock); while (req_stall);
      board.note_request(command, address, write_data);
      @(negedge clock);
   endtask

   // Short directed pass: power-up tag-0 hits, clean and dirty evictions,
   // write misses, ignored write data on reads and the extreme addresses.
   task automatic run_directed();
      // Every line starts as tag 0 with zero bytes, so this read hits clean.
      send_request(CMD_READ,  16'h0000, 8'hFF);
      send_request(CMD_WRITE, 16'h0007, 8'hFF);
      send_request(CMD_READ,  16'h0007, 8'h00);
      send_request(CMD_WRITE, 16'h0000, 8'h00);
      // A different tag in set 0 evicts the dirty line and writes it back.
      send_request(CMD_READ,  16'hFF07, 8'h00);
      // Coming back refills from memory; the victim was clean.
      send_request(CMD_READ,  16'h0007, 8'h00);
      send_request(CMD_READ,  16'hFFFF, 8'h00);
      send_request(CMD_WRITE, 16'hFFFF, 8'hAA);
      // Write miss over a dirty victim: write-back, refill, then the byte.
      send_request(CMD_WRITE, 16'h00F8, 8'h55);
      send_request(CMD_READ,  16'hFFFF, 8'h00);
      send_request(CMD_READ,  16'h00F8, 8'hFF);
      // Write miss over a clean victim keeps the refilled neighbors.
      send_request(CMD_WRITE, 16'h8001, 8'h80);
      send_request(CMD_READ,  16'h8000, 8'h00);
      send_request(CMD_READ,  16'h8001, 8'h00);
      send_request(CMD_READ,  16'h7FFE, 8'h00);
      send_request(CMD_WRITE, 16'h5555, 8'h5A);
      send_request(CMD_WRITE, 16'hAAAA, 8'hA5);
      send_request(CMD_READ,  16'h5555, 8'h00);
      send_request(CMD_READ,  16'hAAAA, 8'h00);
      send_request(CMD_WRITE, 16'h0000, 8'h01);
      send_request(CMD_READ,  16'h0000, 8'h00);
   endtask

   // Most addresses combine a hot tag with a handful of busy sets, so lines
   // collide and carry data across evictions; the rest are fully random.
   function automatic addr_field_type pick_address();
      logic [7:0] tag;
      logic [4:0] set;
      if ($urandom_range(99) < 25)
         return addr_field_type'($urandom);
      tag = hot_tags[$urandom_range(3)];
      set = ($urandom_range(99) < 50) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
      return {tag, set, 3'($urandom_range(7))};
   endfunction

   task automatic run_random(int count, int idle_pct, int stall_percent);
      logic command;
      send_idle_pct = idle_pct;
      stall_pct     = stall_percent;
      hot_tags[0]   = 8'h00;
      hot_tags[1]   = 8'hFF;
      hot_tags[2]   = 8'($urandom);
      hot_tags[3]   = 8'($urandom);
      for (int n = 0; n < count; n++) begin
         command = ($urandom_range(1) == 1) ? CMD_WRITE : CMD_READ;
         send_request(command, pick_address(), byte_type'($urandom));
      end
   endtask

   initial begin
      board.clear();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_READ;
      req_address    = '0;
      req_write_data = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // The clearing pass after reset shows up as a long stall on the first word.
      run_directed();
      run_random(PHASE_ITEMS, 0, 0);
      run_random(PHASE_ITEMS, 79, 0);
      run_random(PHASE_ITEMS, 0, 79);
      run_random(PHASE_ITEMS, 32, 32);
      req_valid <= 1'b0;

      // Drain the outstanding reads, then give a trailing write miss time to finish
      // and any stray response time to show up.
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
